FILE: sv/bpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binomial probability package
// Shared types, state encodings and double precision constants.
// ----------------------------------------------------------------------------
package bpf_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam logic [63:0] FP_ONE  = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] FP_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [63:0] FP_TINY = 64'h0007_30D6_7819_E8D2;
    localparam logic [63:0] FP_QNAN = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] FP_QBIT = 64'h0008_0000_0000_0000;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_MUL,
        OP_DIV,
        OP_I2F
    } fp_op_t;

    typedef struct packed {
        logic        start;
        fp_op_t      op;
        logic [63:0] a;
        logic [63:0] b;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } fpu_rsp_t;

    typedef enum logic [3:0] {
        FS_IDLE,
        FS_PRENORM,
        FS_ALIGN,
        FS_ADDSUB,
        FS_MUL,
        FS_DIV,
        FS_NORM,
        FS_SUBN,
        FS_ROUND,
        FS_DONE
    } fpu_state_t;

    typedef enum logic [3:0] {
        TS_IDLE,
        TS_SUBQ,
        TS_CHECK,
        TS_PQ,
        TS_ITOF_I,
        TS_TMUL,
        TS_ITOF_J,
        TS_TDIV,
        TS_PMUL,
        TS_STEP,
        TS_PWR_SQ,
        TS_PWR_MX,
        TS_PWR_NEXT,
        TS_FINMUL,
        TS_FINCHK,
        TS_DONE
    } top_state_t;

endpackage

FILE: sv/bpf_fpu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative double precision unit
// Add, multiply, divide and integer conversion with one shared normalise
// and round-to-nearest-even path; one bit of work per cycle.
// ----------------------------------------------------------------------------
module bpf_fpu (
    input  logic               clk,
    input  logic               rst_n,
    input  bpf_pkg::fpu_req_t  req,
    output bpf_pkg::fpu_rsp_t  rsp
);
    import bpf_pkg::*;

    fpu_state_t         state_reg, state_next;
    fp_op_t             op_reg, op_next;
    logic               sa_reg, sa_next, sb_reg, sb_next, s_reg, s_next;
    logic signed [15:0] ea_reg, ea_next, eb_reg, eb_next, x_reg, x_next;
    logic [52:0]        ma_reg, ma_next, mb_reg, mb_next;
    logic [127:0]       m_reg, m_next, bal_reg, bal_next;
    logic [53:0]        rem_reg, rem_next;
    logic [7:0]         cnt_reg, cnt_next;
    logic [63:0]        res_reg, res_next;

    logic [10:0] fa_e, fb_e;
    logic [51:0] fa_f, fb_f;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx;
    logic        spec_hit;
    logic [63:0] spec_val;

    assign fa_e   = req.a[62:52];
    assign fa_f   = req.a[51:0];
    assign fb_e   = req.b[62:52];
    assign fb_f   = req.b[51:0];
    assign a_nan  = (fa_e == 11'h7FF) && (fa_f != 52'd0);
    assign b_nan  = (fb_e == 11'h7FF) && (fb_f != 52'd0);
    assign a_inf  = (fa_e == 11'h7FF) && (fa_f == 52'd0);
    assign b_inf  = (fb_e == 11'h7FF) && (fb_f == 52'd0);
    assign a_zero = (req.a[62:0] == 63'd0);
    assign b_zero = (req.b[62:0] == 63'd0);
    assign sx     = req.a[63] ^ req.b[63];

    always_comb
    begin
        spec_hit = 1'b1;
        spec_val = FP_ZERO;
        if (a_nan)
        begin
            spec_val = req.a | FP_QBIT;
        end
        else if (b_nan)
        begin
            spec_val = req.b | FP_QBIT;
        end
        else
        begin
            case (req.op)
                OP_ADD:
                begin
                    if (a_inf && b_inf && (req.a[63] != req.b[63]))
                        spec_val = FP_QNAN;
                    else if (a_inf)
                        spec_val = req.a;
                    else if (b_inf)
                        spec_val = req.b;
                    else if (a_zero && b_zero)
                        spec_val = {req.a[63] & req.b[63], 63'd0};
                    else if (a_zero)
                        spec_val = req.b;
                    else if (b_zero)
                        spec_val = req.a;
                    else
                        spec_hit = 1'b0;
                end
                OP_MUL:
                begin
                    if ((a_inf && b_zero) || (b_inf && a_zero))
                        spec_val = FP_QNAN;
                    else if (a_inf || b_inf)
                        spec_val = {sx, 11'h7FF, 52'd0};
                    else if (a_zero || b_zero)
                        spec_val = {sx, 63'd0};
                    else
                        spec_hit = 1'b0;
                end
                OP_DIV:
                begin
                    if ((a_inf && b_inf) || (a_zero && b_zero))
                        spec_val = FP_QNAN;
                    else if (a_inf || b_zero)
                        spec_val = {sx, 11'h7FF, 52'd0};
                    else if (a_zero || b_inf)
                        spec_val = {sx, 63'd0};
                    else
                        spec_hit = 1'b0;
                end
                default:
                begin
                    spec_hit = 1'b0;
                end
            endcase
        end
    end

    logic               pren_done, swap;
    logic [52:0]        hi_m, lo_m;
    logic signed [15:0] hi_e, lo_e, dexp;
    logic               hi_s, lo_s;
    logic               ge;
    logic [53:0]        diff;
    logic [127:0]       addend;
    logic [52:0]        mant53;
    logic               guard, sticky, inc;
    logic [53:0]        mant54;
    logic [52:0]        mfin;
    logic signed [15:0] be2;
    logic [10:0]        exp_f;

    assign pren_done = ma_reg[52] && mb_reg[52];
    assign swap      = ea_reg < eb_reg;
    assign hi_m      = swap ? mb_reg : ma_reg;
    assign lo_m      = swap ? ma_reg : mb_reg;
    assign hi_e      = swap ? eb_reg : ea_reg;
    assign lo_e      = swap ? ea_reg : eb_reg;
    assign hi_s      = swap ? sb_reg : sa_reg;
    assign lo_s      = swap ? sa_reg : sb_reg;
    assign dexp      = hi_e - lo_e;

    assign ge     = rem_reg >= {1'b0, mb_reg};
    assign diff   = ge ? (rem_reg - {1'b0, mb_reg}) : rem_reg;
    assign addend = mb_reg[52] ? {75'd0, ma_reg} : 128'd0;

    assign mant53 = m_reg[127:75];
    assign guard  = m_reg[74];
    assign sticky = |m_reg[73:0];
    assign inc    = guard & (sticky | mant53[0]);
    assign mant54 = {1'b0, mant53} + {53'd0, inc};
    assign mfin   = mant54[53] ? mant54[53:1] : mant54[52:0];
    assign be2    = x_reg + $signed({15'd0, mant54[53]});
    assign exp_f  = mfin[52] ? be2[10:0] : 11'd0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE:
            begin
                if (req.start)
                begin
                    if (req.op == OP_I2F)
                        state_next = FS_NORM;
                    else if (spec_hit)
                        state_next = FS_DONE;
                    else
                        state_next = FS_PRENORM;
                end
            end
            FS_PRENORM:
            begin
                if (pren_done)
                begin
                    case (op_reg)
                        OP_ADD:  state_next = FS_ALIGN;
                        OP_MUL:  state_next = FS_MUL;
                        OP_DIV:  state_next = FS_DIV;
                        default: state_next = FS_NORM;
                    endcase
                end
            end
            FS_ALIGN:
            begin
                if (cnt_reg == 8'd0)
                    state_next = FS_ADDSUB;
            end
            FS_ADDSUB:
            begin
                state_next = FS_NORM;
            end
            FS_MUL, FS_DIV:
            begin
                if (cnt_reg == 8'd1)
                    state_next = FS_NORM;
            end
            FS_NORM:
            begin
                if (m_reg == 128'd0)
                    state_next = FS_DONE;
                else if (m_reg[127])
                    state_next = FS_SUBN;
            end
            FS_SUBN:
            begin
                if (x_reg >= 16'sd1)
                    state_next = FS_ROUND;
            end
            FS_ROUND:
            begin
                state_next = FS_DONE;
            end
            FS_DONE:
            begin
                state_next = FS_IDLE;
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next  = op_reg;
        sa_next  = sa_reg;
        sb_next  = sb_reg;
        s_next   = s_reg;
        ea_next  = ea_reg;
        eb_next  = eb_reg;
        x_next   = x_reg;
        ma_next  = ma_reg;
        mb_next  = mb_reg;
        m_next   = m_reg;
        bal_next = bal_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        res_next = res_reg;
        case (state_reg)
            FS_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    sa_next  = req.a[63];
                    sb_next  = req.b[63];
                    ea_next  = (fa_e == 11'd0) ? 16'sd1 : $signed({5'd0, fa_e});
                    eb_next  = (fb_e == 11'd0) ? 16'sd1 : $signed({5'd0, fb_e});
                    ma_next  = {fa_e != 11'd0, fa_f};
                    mb_next  = {fb_e != 11'd0, fb_f};
                    res_next = spec_val;
                    if (req.op == OP_I2F)
                    begin
                        m_next = {96'd0, req.a[31:0]};
                        x_next = 16'sd0;
                        s_next = 1'b0;
                    end
                end
            end
            FS_PRENORM:
            begin
                if (!ma_reg[52])
                begin
                    ma_next = {ma_reg[51:0], 1'b0};
                    ea_next = ea_reg - 16'sd1;
                end
                if (!mb_reg[52])
                begin
                    mb_next = {mb_reg[51:0], 1'b0};
                    eb_next = eb_reg - 16'sd1;
                end
                if (pren_done)
                begin
                    case (op_reg)
                        OP_ADD:
                        begin
                            sa_next  = hi_s;
                            sb_next  = lo_s;
                            ea_next  = hi_e;
                            m_next   = {2'd0, hi_m, 73'd0};
                            if (dexp > 16'sd110)
                            begin
                                bal_next = 128'd1;
                                cnt_next = 8'd0;
                            end
                            else
                            begin
                                bal_next = {2'd0, lo_m, 73'd0};
                                cnt_next = dexp[7:0];
                            end
                        end
                        OP_MUL:
                        begin
                            m_next   = 128'd0;
                            cnt_next = 8'd53;
                        end
                        OP_DIV:
                        begin
                            m_next   = 128'd0;
                            rem_next = {1'b0, ma_reg};
                            cnt_next = 8'd56;
                        end
                        default:
                        begin
                            cnt_next = 8'd0;
                        end
                    endcase
                end
            end
            FS_ALIGN:
            begin
                if (cnt_reg != 8'd0)
                begin
                    bal_next = {1'b0, bal_reg[127:1]} | {127'd0, bal_reg[0]};
                    cnt_next = cnt_reg - 8'd1;
                end
            end
            FS_ADDSUB:
            begin
                x_next = ea_reg - 16'sd1148;
                if (sa_reg == sb_reg)
                begin
                    m_next = m_reg + bal_reg;
                    s_next = sa_reg;
                end
                else if (m_reg == bal_reg)
                begin
                    m_next = 128'd0;
                    s_next = 1'b0;
                end
                else if (m_reg > bal_reg)
                begin
                    m_next = m_reg - bal_reg;
                    s_next = sa_reg;
                end
                else
                begin
                    m_next = bal_reg - m_reg;
                    s_next = sb_reg;
                end
            end
            FS_MUL:
            begin
                m_next   = {m_reg[126:0], 1'b0} + addend;
                mb_next  = {mb_reg[51:0], 1'b0};
                cnt_next = cnt_reg - 8'd1;
                x_next   = ea_reg + eb_reg - 16'sd2150;
                s_next   = sa_reg ^ sb_reg;
            end
            FS_DIV:
            begin
                rem_next = {diff[52:0], 1'b0};
                m_next   = {m_reg[126:0], ge | ((cnt_reg == 8'd1) && (diff != 54'd0))};
                cnt_next = cnt_reg - 8'd1;
                x_next   = ea_reg - eb_reg - 16'sd55;
                s_next   = sa_reg ^ sb_reg;
            end
            FS_NORM:
            begin
                if (m_reg == 128'd0)
                begin
                    res_next = {s_reg, 63'd0};
                end
                else if (!m_reg[127])
                begin
                    m_next = {m_reg[126:0], 1'b0};
                    x_next = x_reg - 16'sd1;
                end
                else
                begin
                    x_next = x_reg + 16'sd1150;
                end
            end
            FS_SUBN:
            begin
                if (x_reg < -16'sd60)
                begin
                    m_next = 128'd1;
                    x_next = 16'sd1;
                end
                else if (x_reg < 16'sd1)
                begin
                    m_next = {1'b0, m_reg[127:1]} | {127'd0, m_reg[0]};
                    x_next = x_reg + 16'sd1;
                end
            end
            FS_ROUND:
            begin
                if (be2 >= 16'sd2047)
                    res_next = {s_reg, 11'h7FF, 52'd0};
                else
                    res_next = {s_reg, exp_f, mfin[51:0]};
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            cnt_reg   <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        s_reg   <= s_next;
        ea_reg  <= ea_next;
        eb_reg  <= eb_next;
        x_reg   <= x_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        m_reg   <= m_next;
        bal_reg <= bal_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign rsp.done   = (state_reg == FS_DONE);
    assign rsp.result = res_reg;

endmodule

FILE: sv/binomial_probability_fp64.sv
`timescale 1ns / 1ps
// A rejected request gives its result strobe in the cycle after the transfer;
// otherwise each double operation runs in the shared unit (53 multiply or 56 divide
// iterations, then normalise and round) and an item needs up to 3 + 5*min(k,n-k) +
// 2*COUNT_BITS operations.
// A new item is taken only once the block is idle again; busy stays high through the strobe.
// Reset is asynchronous and active low; the block then idles, and the receiver cannot stall.
// ----------------------------------------------------------------------------
// Binomial probability, double precision
// Sequencer around one iterative double unit computing the binomial mass.
// ----------------------------------------------------------------------------
module binomial_probability_fp64 #(
    parameter int COUNT_BITS = bpf_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] trials,
    input  logic [15:0] successes,
    input  logic [63:0] success_prob,
    output logic        done,
    output logic [63:0] probability,
    output logic        bad_request
);
    import bpf_pkg::*;

    localparam int BW = $clog2(COUNT_BITS);

    top_state_t            state_reg, state_next;
    logic                  iss_reg, iss_next;
    logic [COUNT_BITS-1:0] n_reg, n_next, k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic [COUNT_BITS-1:0] e_reg, e_next;
    logic [BW-1:0]         bit_reg, bit_next;
    logic                  fin_reg, fin_next, bad_reg, bad_next;
    logic [63:0]           p_reg, p_next, q_reg, q_next, pq_reg, pq_next;
    logic [63:0]           prod_reg, prod_next, t_reg, t_next, u_reg, u_next;
    logic [63:0]           r_reg, r_next, base_reg, base_next, res_reg, res_next;

    logic [31:0]           trials_ext, successes_ext;
    logic [COUNT_BITS-1:0] n_in, k_in, nk, steps;
    logic                  op_state, op_done;
    logic                  p_nan;
    fpu_req_t              req;
    fpu_rsp_t              rsp;

    assign trials_ext    = {16'd0, trials};
    assign successes_ext = {16'd0, successes};
    assign n_in          = trials_ext[COUNT_BITS-1:0];
    assign k_in          = successes_ext[COUNT_BITS-1:0];
    assign nk            = n_reg - k_reg;
    assign steps         = (k_reg < nk) ? k_reg : nk;
    assign p_nan         = (p_reg[62:52] == 11'h7FF) && (p_reg[51:0] != 52'd0);

    always_comb
    begin
        case (state_reg)
            TS_SUBQ, TS_PQ, TS_ITOF_I, TS_TMUL, TS_ITOF_J, TS_TDIV, TS_PMUL,
            TS_PWR_SQ, TS_PWR_MX, TS_FINMUL: op_state = 1'b1;
            default:                          op_state = 1'b0;
        endcase
    end

    assign op_done = op_state && iss_reg && rsp.done;

    always_comb
    begin
        req.start = op_state && !iss_reg;
        req.op    = OP_MUL;
        req.a     = FP_ZERO;
        req.b     = FP_ZERO;
        case (state_reg)
            TS_SUBQ:
            begin
                req.op = OP_ADD;
                req.a  = FP_ONE;
                req.b  = p_nan ? p_reg : {~p_reg[63], p_reg[62:0]};
            end
            TS_PQ:
            begin
                req.a = p_reg;
                req.b = q_reg;
            end
            TS_ITOF_I:
            begin
                req.op = OP_I2F;
                req.a  = {{(64-COUNT_BITS){1'b0}}, i_reg};
            end
            TS_TMUL:
            begin
                req.a = t_reg;
                req.b = pq_reg;
            end
            TS_ITOF_J:
            begin
                req.op = OP_I2F;
                req.a  = {{(64-COUNT_BITS){1'b0}}, j_reg};
            end
            TS_TDIV:
            begin
                req.op = OP_DIV;
                req.a  = t_reg;
                req.b  = u_reg;
            end
            TS_PMUL:
            begin
                req.a = prod_reg;
                req.b = t_reg;
            end
            TS_PWR_SQ:
            begin
                req.a = r_reg;
                req.b = r_reg;
            end
            TS_PWR_MX:
            begin
                req.a = r_reg;
                req.b = base_reg;
            end
            TS_FINMUL:
            begin
                req.a = prod_reg;
                req.b = r_reg;
            end
            default:
            begin
                req.a = FP_ZERO;
            end
        endcase
    end

    bpf_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TS_IDLE:
            begin
                if (start)
                    state_next = (k_in > n_in) ? TS_DONE : TS_SUBQ;
            end
            TS_SUBQ:
            begin
                if (op_done)
                    state_next = TS_CHECK;
            end
            TS_CHECK:
            begin
                if ((k_reg == '0) || (k_reg == n_reg))
                    state_next = TS_PWR_SQ;
                else if ((p_reg[62:0] == 63'd0) || (q_reg[62:0] == 63'd0))
                    state_next = TS_DONE;
                else
                    state_next = TS_PQ;
            end
            TS_PQ:     if (op_done) state_next = TS_ITOF_I;
            TS_ITOF_I: if (op_done) state_next = TS_TMUL;
            TS_TMUL:   if (op_done) state_next = TS_ITOF_J;
            TS_ITOF_J: if (op_done) state_next = TS_TDIV;
            TS_TDIV:   if (op_done) state_next = TS_PMUL;
            TS_PMUL:   if (op_done) state_next = TS_STEP;
            TS_STEP:
            begin
                if (j_reg != {{(COUNT_BITS-1){1'b0}}, 1'b1})
                    state_next = TS_ITOF_I;
                else if (nk != k_reg)
                    state_next = TS_PWR_SQ;
                else
                    state_next = TS_FINCHK;
            end
            TS_PWR_SQ:
            begin
                if (op_done)
                    state_next = e_reg[bit_reg] ? TS_PWR_MX : TS_PWR_NEXT;
            end
            TS_PWR_MX:
            begin
                if (op_done)
                    state_next = TS_PWR_NEXT;
            end
            TS_PWR_NEXT:
            begin
                if (bit_reg != '0)
                    state_next = TS_PWR_SQ;
                else
                    state_next = fin_reg ? TS_FINMUL : TS_DONE;
            end
            TS_FINMUL:
            begin
                if (op_done)
                    state_next = TS_FINCHK;
            end
            TS_FINCHK:
            begin
                state_next = TS_DONE;
            end
            TS_DONE:
            begin
                state_next = TS_IDLE;
            end
            default:
            begin
                state_next = TS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        iss_next  = iss_reg;
        n_next    = n_reg;
        k_next    = k_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        e_next    = e_reg;
        bit_next  = bit_reg;
        fin_next  = fin_reg;
        bad_next  = bad_reg;
        p_next    = p_reg;
        q_next    = q_reg;
        pq_next   = pq_reg;
        prod_next = prod_reg;
        t_next    = t_reg;
        u_next    = u_reg;
        r_next    = r_reg;
        base_next = base_reg;
        res_next  = res_reg;
        if (req.start)
            iss_next = 1'b1;
        if (op_done)
            iss_next = 1'b0;
        case (state_reg)
            TS_IDLE:
            begin
                if (start)
                begin
                    n_next   = n_in;
                    k_next   = k_in;
                    p_next   = success_prob;
                    bad_next = k_in > n_in;
                    res_next = FP_ZERO;
                end
            end
            TS_SUBQ:
            begin
                if (op_done)
                    q_next = rsp.result;
            end
            TS_CHECK:
            begin
                r_next   = FP_ONE;
                bit_next = BW'(COUNT_BITS - 1);
                e_next   = n_reg;
                fin_next = 1'b0;
                base_next = (k_reg == '0) ? q_reg : p_reg;
                res_next = FP_ZERO;
                i_next   = n_reg;
                j_next   = steps;
                prod_next = FP_ONE;
            end
            TS_PQ:     if (op_done) pq_next = rsp.result;
            TS_ITOF_I: if (op_done) t_next = rsp.result;
            TS_TMUL:   if (op_done) t_next = rsp.result;
            TS_ITOF_J: if (op_done) u_next = rsp.result;
            TS_TDIV:   if (op_done) t_next = rsp.result;
            TS_PMUL:   if (op_done) prod_next = rsp.result;
            TS_STEP:
            begin
                i_next    = i_reg - {{(COUNT_BITS-1){1'b0}}, 1'b1};
                j_next    = j_reg - {{(COUNT_BITS-1){1'b0}}, 1'b1};
                r_next    = FP_ONE;
                bit_next  = BW'(COUNT_BITS - 1);
                fin_next  = 1'b1;
                base_next = (nk < k_reg) ? p_reg : q_reg;
                e_next    = (nk < k_reg) ? (k_reg - nk) : (nk - k_reg);
            end
            TS_PWR_SQ, TS_PWR_MX:
            begin
                if (op_done)
                    r_next = rsp.result;
            end
            TS_PWR_NEXT:
            begin
                if (bit_reg != '0)
                    bit_next = bit_reg - {{(BW-1){1'b0}}, 1'b1};
                else
                    res_next = r_reg;
            end
            TS_FINMUL:
            begin
                if (op_done)
                    prod_next = rsp.result;
            end
            TS_FINCHK:
            begin
                res_next = (prod_reg[62:0] == 63'd0) ? FP_TINY : prod_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TS_IDLE;
            iss_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iss_reg   <= iss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        k_reg    <= k_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        e_reg    <= e_next;
        bit_reg  <= bit_next;
        fin_reg  <= fin_next;
        bad_reg  <= bad_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        pq_reg   <= pq_next;
        prod_reg <= prod_next;
        t_reg    <= t_next;
        u_reg    <= u_next;
        r_reg    <= r_next;
        base_reg <= base_next;
        res_reg  <= res_next;
    end

    assign busy        = (state_reg != TS_IDLE);
    assign done        = (state_reg == TS_DONE);
    assign probability = res_reg;
    assign bad_request = bad_reg;

endmodule

FILE: sv/bpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binomial probability port checker
// Watches the command and result ports of the top level over time.
// ----------------------------------------------------------------------------
module bpf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [63:0] probability,
    input logic        bad_request
);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("Result strobe seen while the block is idle.");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted transfer did not raise busy.");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe held for more than one cycle.");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_request) |-> (probability == 64'd0))
        else $error("Rejected request did not give a zero probability.");

endmodule

bind binomial_probability_fp64 bpf_checker u_bpf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .probability (probability),
    .bad_request (bad_request)
);
